@@ hdl/encoder_button_event_queue_defines.svh @@
// Assertion macros for the encoder and button event queue.
// No dependencies; included by files that carry concurrent checks.
`ifndef ENCODER_BUTTON_EVENT_QUEUE_DEFINES_SVH
`define ENCODER_BUTTON_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EBQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define EBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ebq_pkg.sv @@
// Shared types and constants for the encoder and button event queue.
// No dependencies.
package ebq_pkg;

   // action codes of an input word
   typedef logic [1:0] action_type;
   localparam action_type ACT_TICK    = 2'd0;
   localparam action_type ACT_POP_ENC = 2'd1;
   localparam action_type ACT_POP_BTN = 2'd2;

   localparam int TICKS_W = 16;
   localparam int FILL_W  = 4;
   localparam int KEY_W   = 2;

   typedef logic [TICKS_W-1:0] ticks_type;

   localparam ticks_type DEBOUNCE_RESET = 16'd50;

   // button queue entry: level and button index
   typedef struct packed {
      logic level;
      logic button;
   } btn_entry_type;

endpackage

@@ hdl/encoder_button_event_queue.sv @@
// Encoder and two-button event queue: input register, update logic, result register.
// A request word is held in the input register, then its result word in the result register.
// Throughput: one request word per cycle; req_stall rises only while a result is held.
// Reset (synchronous): queues empty, timers idle, debounce period 50; queue RAMs
// are not cleared and need no clearing pass.
// Depends on ebq_pkg and encoder_button_event_queue_defines.svh.
`include "encoder_button_event_queue_defines.svh"

module encoder_button_event_queue
   import ebq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic                req_enc_a,
   input  logic                req_enc_b,
   input  logic                req_button_one,
   input  logic                req_button_two,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_entry_valid,
   output logic [KEY_W-1:0]    rsp_entry_key,
   output logic                rsp_entry_type,
   output logic [FILL_W-1:0]   rsp_encoder_fill,
   output logic [FILL_W-1:0]   rsp_button_fill,
   // debounce register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [TICKS_W-1:0]  csr_debounce_ticks
);

   // ring is a power of two of at least four slots; occupancy capped at depth - 1
   localparam int PTR_W      = ($clog2(QUEUE_DEPTH) < 2) ? 2 : $clog2(QUEUE_DEPTH);
   localparam int RING       = 1 << PTR_W;
   localparam int BANK_W     = PTR_W - 1;
   localparam int BANK_DEPTH = 1 << BANK_W;
   localparam logic [PTR_W-1:0] CNT_MAX = PTR_W'(QUEUE_DEPTH - 1);

   // input register
   logic        in_valid_ff, in_valid_in;
   action_type  in_action_ff;
   logic        in_a_ff, in_b_ff;
   logic [1:0]  in_btn_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_entry_valid_ff;
   logic [KEY_W-1:0]   rsp_entry_key_ff;
   logic               rsp_entry_type_ff;
   logic [FILL_W-1:0]  rsp_encoder_fill_ff;
   logic [FILL_W-1:0]  rsp_button_fill_ff;

   // configuration
   ticks_type  cfg_ticks_ff;
   ticks_type  reload;

   // control state
   logic                     primed_ff, primed_in;
   logic                     last_a_ff, last_a_in;
   logic [PTR_W-1:0]         enc_head_ff, enc_head_in;
   logic [PTR_W-1:0]         enc_cnt_ff, enc_cnt_in;
   logic [PTR_W-1:0]         btn_head_ff, btn_head_in;
   logic [PTR_W-1:0]         btn_cnt_ff, btn_cnt_in;
   logic [1:0]               ref_ff, ref_in;
   logic [1:0]               wait_ff, wait_in;
   logic [1:0]               cap_ff, cap_in;
   logic [1:0]               edw_ff, edw_in;
   logic [1:0][TICKS_W-1:0]  timer_ff, timer_in;

   // queue storage and prefetched head words
   logic                  enc_mem_ff [RING];
   logic                  enc_rd_ff;
   btn_entry_type         btn_mem_ff [2][BANK_DEPTH];
   btn_entry_type         btn_rd_ff [2];
   btn_entry_type         btn_head_word;

   // write requests
   logic                       enc_we;
   logic [PTR_W-1:0]           enc_waddr;
   logic                       enc_wdata;
   logic [1:0]                 btn_push;
   logic [1:0][PTR_W-1:0]      btn_paddr;
   btn_entry_type [1:0]        btn_pdata;
   logic [1:0]                 bank_we;
   logic [1:0][BANK_W-1:0]     bank_waddr;
   btn_entry_type [1:0]        bank_wdata;

   // result of the word in the input register
   logic               res_valid;
   logic [KEY_W-1:0]   res_key;
   logic               res_type;
   logic [PTR_W+FILL_W-1:0] enc_fill_ext;
   logic [PTR_W+FILL_W-1:0] btn_fill_ext;

   logic advance;
   logic accept;

   // handshake: the result register decouples the two sides
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   assign reload        = (cfg_ticks_ff == '0) ? TICKS_W'(1) : cfg_ticks_ff;
   assign btn_head_word = btn_head_ff[0] ? btn_rd_ff[1] : btn_rd_ff[0];

   // update the queues, encoder and debounce state for the held word
   always_comb begin
      logic lvl;
      logic edge_seen;
      primed_in   = primed_ff;
      last_a_in   = last_a_ff;
      enc_head_in = enc_head_ff;
      enc_cnt_in  = enc_cnt_ff;
      btn_head_in = btn_head_ff;
      btn_cnt_in  = btn_cnt_ff;
      ref_in      = ref_ff;
      wait_in     = wait_ff;
      cap_in      = cap_ff;
      edw_in      = edw_ff;
      timer_in    = timer_ff;
      enc_we      = 1'b0;
      enc_waddr   = enc_head_ff + enc_cnt_ff;
      enc_wdata   = (in_a_ff == in_b_ff);
      btn_push    = '0;
      btn_paddr   = '0;
      btn_pdata   = '0;
      res_valid   = 1'b0;
      res_key     = '0;
      res_type    = 1'b0;
      lvl         = 1'b0;
      edge_seen   = 1'b0;
      if (advance) begin
         unique case (in_action_ff)
            ACT_TICK: begin
               if (!primed_ff) begin
                  // first tick only loads the reference levels
                  last_a_in = in_a_ff;
                  ref_in    = in_btn_ff;
                  primed_in = 1'b1;
               end else begin
                  // encoder direction on a change of channel A
                  if (in_a_ff != last_a_ff && enc_cnt_ff < CNT_MAX) begin
                     enc_we     = 1'b1;
                     enc_cnt_in = enc_cnt_ff + 1'b1;
                  end
                  last_a_in = in_a_ff;
                  // debounce each button, first button pushes first
                  for (int i = 0; i < 2; i++) begin
                     lvl       = in_btn_ff[i];
                     edge_seen = (ref_ff[i] != lvl);
                     ref_in[i] = lvl;
                     if (!wait_ff[i]) begin
                        if (edge_seen) begin
                           cap_in[i]   = lvl;
                           timer_in[i] = reload;
                           wait_in[i]  = 1'b1;
                           edw_in[i]   = 1'b0;
                        end
                     end else if (edge_seen) begin
                        timer_in[i] = reload;
                        edw_in[i]   = 1'b1;
                     end else begin
                        timer_in[i] = timer_ff[i] - 1'b1;
                        if (timer_ff[i] == TICKS_W'(1)) begin
                           wait_in[i] = 1'b0;
                           edw_in[i]  = 1'b0;
                           if (cap_ff[i] == lvl && btn_cnt_in < CNT_MAX) begin
                              btn_push[i]         = 1'b1;
                              btn_paddr[i]        = btn_head_ff + btn_cnt_in;
                              btn_pdata[i].level  = lvl;
                              btn_pdata[i].button = 1'(i);
                              btn_cnt_in          = btn_cnt_in + 1'b1;
                           end
                        end
                     end
                  end
               end
            end
            ACT_POP_ENC: begin
               if (enc_cnt_ff != '0) begin
                  res_valid   = 1'b1;
                  res_key     = {1'b0, enc_rd_ff};
                  enc_head_in = enc_head_ff + 1'b1;
                  enc_cnt_in  = enc_cnt_ff - 1'b1;
               end
            end
            ACT_POP_BTN: begin
               if (btn_cnt_ff != '0) begin
                  res_valid   = 1'b1;
                  res_key     = {1'b1, btn_head_word.button};
                  res_type    = btn_head_word.level;
                  btn_head_in = btn_head_ff + 1'b1;
                  btn_cnt_in  = btn_cnt_ff - 1'b1;
               end
            end
            default: begin
               // unused action: no state change
            end
         endcase
      end
   end

   // steer the one or two button pushes to the even and odd banks
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         if (btn_push[1] && btn_paddr[1][0] == 1'(b)) begin
            bank_we[b]    = 1'b1;
            bank_waddr[b] = btn_paddr[1][PTR_W-1:1];
            bank_wdata[b] = btn_pdata[1];
         end else begin
            bank_we[b]    = btn_push[0] && btn_paddr[0][0] == 1'(b);
            bank_waddr[b] = btn_paddr[0][PTR_W-1:1];
            bank_wdata[b] = btn_pdata[0];
         end
      end
   end

   // fill counts, zero-extended or truncated to the port width
   assign enc_fill_ext = {{FILL_W{1'b0}}, enc_cnt_in};
   assign btn_fill_ext = {{FILL_W{1'b0}}, btn_cnt_in};

   // encoder queue RAM: write the tail, prefetch the next head with bypass
   always_ff @(posedge clock) begin
      if (enc_we && enc_waddr == enc_head_in) begin
         enc_rd_ff <= enc_wdata;
      end else begin
         enc_rd_ff <= enc_mem_ff[enc_head_in];
      end
      if (enc_we) begin
         enc_mem_ff[enc_waddr] <= enc_wdata;
      end
   end

   // button queue RAM banks: one write port each, prefetch at the next head row
   for (genvar b = 0; b < 2; b++) begin : g_btn_bank
      always_ff @(posedge clock) begin
         if (bank_we[b] && bank_waddr[b] == btn_head_in[PTR_W-1:1]) begin
            btn_rd_ff[b] <= bank_wdata[b];
         end else begin
            btn_rd_ff[b] <= btn_mem_ff[b][btn_head_in[PTR_W-1:1]];
         end
         if (bank_we[b]) begin
            btn_mem_ff[b][bank_waddr[b]] <= bank_wdata[b];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ticks_ff <= DEBOUNCE_RESET;
         primed_ff    <= 1'b0;
         last_a_ff    <= 1'b0;
         enc_head_ff  <= '0;
         enc_cnt_ff   <= '0;
         btn_head_ff  <= '0;
         btn_cnt_ff   <= '0;
         ref_ff       <= '0;
         wait_ff      <= '0;
         cap_ff       <= '0;
         edw_ff       <= '0;
         timer_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cfg_ticks_ff <= csr_debounce_ticks;
         end
         primed_ff    <= primed_in;
         last_a_ff    <= last_a_in;
         enc_head_ff  <= enc_head_in;
         enc_cnt_ff   <= enc_cnt_in;
         btn_head_ff  <= btn_head_in;
         btn_cnt_ff   <= btn_cnt_in;
         ref_ff       <= ref_in;
         wait_ff      <= wait_in;
         cap_ff       <= cap_in;
         edw_ff       <= edw_in;
         timer_ff     <= timer_in;
      end
   end

   // payload registers: load the request word, then the result word
   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_a_ff      <= req_enc_a;
         in_b_ff      <= req_enc_b;
         in_btn_ff    <= {req_button_two, req_button_one};
      end
      if (advance) begin
         rsp_entry_valid_ff  <= res_valid;
         rsp_entry_key_ff    <= res_key;
         rsp_entry_type_ff   <= res_type;
         rsp_encoder_fill_ff <= enc_fill_ext[FILL_W-1:0];
         rsp_button_fill_ff  <= btn_fill_ext[FILL_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_valid  = rsp_entry_valid_ff;
   assign rsp_entry_key    = rsp_entry_key_ff;
   assign rsp_entry_type   = rsp_entry_type_ff;
   assign rsp_encoder_fill = rsp_encoder_fill_ff;
   assign rsp_button_fill  = rsp_button_fill_ff;

   // checks
   `EBQ_ASSERT_IMPLY(a_cnt_cap, clock, reset, 1'b1,
      (enc_cnt_ff <= CNT_MAX) && (btn_cnt_ff <= CNT_MAX), "queue count above limit")
   `EBQ_ASSERT_IMPLY(a_timer_live, clock, reset, 1'b1,
      (!wait_ff[0] || timer_ff[0] != '0) && (!wait_ff[1] || timer_ff[1] != '0),
      "debounce wait with expired timer")
   `EBQ_ASSERT_IMPLY(a_edw_waiting, clock, reset, 1'b1,
      (edw_ff & ~wait_ff) == 2'b00, "edge flag set outside a wait")
   `EBQ_ASSERT_NEXT(a_pop_enc, clock, reset,
      advance && in_action_ff == ACT_POP_ENC && enc_cnt_ff != '0,
      rsp_entry_valid_ff && enc_cnt_ff == $past(enc_cnt_ff) - 1'b1,
      "encoder pop lost its entry")
   `EBQ_ASSERT_NEXT(a_tick_no_entry, clock, reset,
      advance && in_action_ff == ACT_TICK, !rsp_entry_valid_ff,
      "sample tick returned an entry")

endmodule

@@ verif/tb.sv @@
// Self-checking bench for encoder_button_event_queue: random request words
// against a cycle-free predictor of both event queues and the debounce timers.
// Depends on ebq_pkg and the encoder_button_event_queue RTL.
`timescale 1ns / 100ps

module tb;
   import ebq_pkg::*;

   localparam int QDEPTH = 16;
   localparam int LIMIT = 400000;
   localparam action_type ACT_IGNORED = 2'd3;

   typedef struct packed {
      action_type action;
      logic       enc_a;
      logic       enc_b;
      logic       button_one;
      logic       button_two;
   } sample_word_type;

   typedef struct packed {
      logic              entry_valid;
      logic [KEY_W-1:0]  entry_key;
      logic              entry_type;
      logic [FILL_W-1:0] encoder_fill;
      logic [FILL_W-1:0] button_fill;
   } result_word_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_action = ACT_TICK;
   logic                req_enc_a = 1'b0;
   logic                req_enc_b = 1'b0;
   logic                req_button_one = 1'b0;
   logic                req_button_two = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_entry_valid;
   logic [KEY_W-1:0]    rsp_entry_key;
   logic                rsp_entry_type;
   logic [FILL_W-1:0]   rsp_encoder_fill;
   logic [FILL_W-1:0]   rsp_button_fill;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [TICKS_W-1:0]  csr_debounce_ticks = DEBOUNCE_RESET;

   encoder_button_event_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_enc_a          (req_enc_a),
      .req_enc_b          (req_enc_b),
      .req_button_one     (req_button_one),
      .req_button_two     (req_button_two),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_type     (rsp_entry_type),
      .rsp_encoder_fill   (rsp_encoder_fill),
      .rsp_button_fill    (rsp_button_fill),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_debounce_ticks (csr_debounce_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor state: both event queues, encoder history, debounce
   // ---------------------------------------------------------------
   ticks_type     debounce = DEBOUNCE_RESET;
   logic          last_a = 1'b0;
   logic          primed = 1'b0;
   logic [1:0]    btn_ref = 2'b00;
   logic [1:0]    waiting = 2'b00;
   logic [1:0]    captured = 2'b00;
   ticks_type     wait_left [2] = '{16'd0, 16'd0};
   logic          enc_fifo [$];
   btn_entry_type btn_fifo [$];

   sample_word_type words_to_send [$];
   result_word_type results_due [$];

   int error_count = 0;
   int words_sent = 0;
   int results_seen = 0;
   int enc_popped = 0;
   int btn_popped = 0;
   int enc_peak = 0;
   int btn_peak = 0;
   int cycle_count = 0;

   // Advance one button's debounce wait by a sample tick
   function automatic void debounce_step(int i, logic level);
      logic      changed;
      ticks_type reload;
      btn_entry_type e;
      changed = (btn_ref[i] != level);
      reload = (debounce == '0) ? ticks_type'(1) : debounce;
      btn_ref[i] = level;
      if (!waiting[i]) begin
         if (changed) begin
            captured[i] = level;
            wait_left[i] = reload;
            waiting[i] = 1'b1;
         end
         return;
      end
      // a bounce restarts the wait, keeping the first captured level
      if (changed) begin
         wait_left[i] = reload;
         return;
      end
      wait_left[i] = wait_left[i] - 1'b1;
      if (wait_left[i] == '0) begin
         waiting[i] = 1'b0;
         if (captured[i] == level && btn_fifo.size() < QDEPTH - 1) begin
            e.level = level;
            e.button = 1'(i);
            btn_fifo.push_back(e);
         end
      end
   endfunction

   // Apply one request word and return the result it produces
   function automatic result_word_type queue_update(sample_word_type w);
      result_word_type r;
      btn_entry_type   e;
      r = '0;
      case (w.action)
         ACT_TICK: begin
            if (!primed) begin
               last_a = w.enc_a;
               btn_ref = {w.button_two, w.button_one};
               primed = 1'b1;
            end else begin
               // push direction on an A transition, drop when full
               if (w.enc_a != last_a && enc_fifo.size() < QDEPTH - 1)
                  enc_fifo.push_back(w.enc_a == w.enc_b);
               last_a = w.enc_a;
               debounce_step(0, w.button_one);
               debounce_step(1, w.button_two);
            end
         end
         ACT_POP_ENC: begin
            if (enc_fifo.size() > 0) begin
               r.entry_valid = 1'b1;
               r.entry_key = {1'b0, enc_fifo.pop_front()};
            end
         end
         ACT_POP_BTN: begin
            if (btn_fifo.size() > 0) begin
               e = btn_fifo.pop_front();
               r.entry_valid = 1'b1;
               r.entry_key = {1'b1, e.button};
               r.entry_type = e.level;
            end
         end
         default: ;
      endcase
      r.encoder_fill = FILL_W'(enc_fifo.size());
      r.button_fill = FILL_W'(btn_fifo.size());
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  results_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Sender: bursts of words with random gaps
   // ---------------------------------------------------------------
   sample_word_type offered = '0;
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : sender
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict the word accepted at this edge
         if (req_valid && !req_stall) begin
            results_due.push_back(queue_update(offered));
            words_sent <= words_sent + 1;
         end
         // hold a stalled word, otherwise advance
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (words_to_send.size() > 0) begin
               offered = words_to_send.pop_front();
               offer = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  burst_left = 60;
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = $urandom_range(1, 6);
               end
            end
            req_valid <= offer;
            req_action <= offered.action;
            req_enc_a <= offered.enc_a;
            req_enc_b <= offered.enc_b;
            req_button_one <= offered.button_one;
            req_button_two <= offered.button_two;
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: rotating stall pattern plus one long hold-off
   // ---------------------------------------------------------------
   logic [7:0] stall_pattern = 8'h00;
   int pattern_age = 0;
   int hold_left = 0;
   logic held_once = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!held_once && results_seen >= 400) begin
         held_once <= 1'b1;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (pattern_age == 0) begin
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
         pattern_age <= 48;
         rsp_stall <= 1'b0;
      end else begin
         stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
         pattern_age <= pattern_age - 1;
         rsp_stall <= stall_pattern[0];
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compare each accepted result word with the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (results_due.size() == 0) begin
            report_mismatch("unexpected result", 16'd1, 16'd0);
         end else begin
            want = results_due.pop_front();
            if (rsp_entry_valid !== want.entry_valid)
               report_mismatch("entry_valid", 16'(rsp_entry_valid), 16'(want.entry_valid));
            if (rsp_entry_key !== want.entry_key)
               report_mismatch("entry_key", 16'(rsp_entry_key), 16'(want.entry_key));
            if (rsp_entry_type !== want.entry_type)
               report_mismatch("entry_type", 16'(rsp_entry_type), 16'(want.entry_type));
            if (rsp_encoder_fill !== want.encoder_fill)
               report_mismatch("encoder_fill", 16'(rsp_encoder_fill),
                               16'(want.encoder_fill));
            if (rsp_button_fill !== want.button_fill)
               report_mismatch("button_fill", 16'(rsp_button_fill),
                               16'(want.button_fill));
            if (want.entry_valid && want.entry_key[1])
               btn_popped++;
            else if (want.entry_valid)
               enc_popped++;
            if (int'(want.encoder_fill) > enc_peak)
               enc_peak = int'(want.encoder_fill);
            if (int'(want.button_fill) > btn_peak)
               btn_peak = int'(want.button_fill);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[encoder_button_event_queue] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   logic [1:0] enc_phase = 2'b00;
   logic       spin_cw = 1'b1;
   logic [1:0] btn_level = 2'b11;
   int         btn_hold [2] = '{0, 0};
   int         pop_pct = 30;

   task automatic add_word(action_type act, logic a, logic b, logic b1, logic b2);
      sample_word_type w;
      w.action = act;
      w.enc_a = a;
      w.enc_b = b;
      w.button_one = b1;
      w.button_two = b2;
      words_to_send.push_back(w);
   endtask

   // Queue count counted words: mostly quadrature steps and button presses
   // held around the debounce span, with pops in segments of varying density
   task automatic queue_random(int count, int hold_span);
      sample_word_type w;
      int made;
      int seg;
      int r;
      made = 0;
      seg = 0;
      while (made < count) begin
         if (seg == 0) begin
            seg = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0: pop_pct = 4;
               1: pop_pct = 30;
               default: pop_pct = 60;
            endcase
         end
         seg--;
         w.enc_a = 1'($urandom);
         w.enc_b = 1'($urandom);
         w.button_one = 1'($urandom);
         w.button_two = 1'($urandom);
         r = $urandom_range(0, 99);
         if (r == 99) begin
            w.action = ACT_IGNORED;
         end else if (r < pop_pct / 2) begin
            w.action = ACT_POP_ENC;
         end else if (r < pop_pct) begin
            w.action = ACT_POP_BTN;
         end else begin
            w.action = ACT_TICK;
            // leave one tick in twenty as random noise
            if ($urandom_range(0, 19) != 0) begin
               if ($urandom_range(0, 9) == 0)
                  spin_cw = !spin_cw;
               if ($urandom_range(0, 1) == 0)
                  enc_phase = spin_cw ? enc_phase + 2'd1 : enc_phase - 2'd1;
               w.enc_a = enc_phase[1];
               w.enc_b = enc_phase[1] ^ enc_phase[0];
               for (int i = 0; i < 2; i++) begin
                  if (btn_hold[i] == 0) begin
                     btn_level[i] = !btn_level[i];
                     btn_hold[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                             : $urandom_range(1, hold_span);
                  end else begin
                     btn_hold[i]--;
                  end
               end
               w.button_one = btn_level[0];
               w.button_two = btn_level[1];
            end
         end
         words_to_send.push_back(w);
         if (w.action != ACT_IGNORED)
            made++;
      end
   endtask

   // Wait until every queued word is sent and every predicted result has come back
   task automatic drain();
      while (words_to_send.size() > 0 || req_valid || results_due.size() > 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_debounce(ticks_type v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_debounce_ticks <= v;
      do @(posedge clock); while (!csr_ready);
      debounce = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pops before priming, priming tick, both directions,
      // a bounce that restarts the wait and ends on the other level,
      // a clean press, simultaneous edges on both buttons, drained queues
      write_debounce(16'd2);
      add_word(ACT_POP_ENC, 1, 0, 0, 1);
      add_word(ACT_POP_BTN, 0, 1, 1, 0);
      add_word(ACT_IGNORED, 1, 1, 0, 0);
      add_word(ACT_TICK, 1, 1, 1, 1);
      add_word(ACT_TICK, 0, 1, 1, 1);
      add_word(ACT_TICK, 1, 1, 1, 1);
      add_word(ACT_TICK, 1, 0, 0, 1);
      add_word(ACT_TICK, 1, 0, 1, 1);
      add_word(ACT_TICK, 1, 0, 1, 1);
      add_word(ACT_TICK, 1, 0, 1, 1);
      add_word(ACT_TICK, 1, 0, 1, 0);
      add_word(ACT_TICK, 0, 0, 1, 0);
      add_word(ACT_TICK, 0, 0, 1, 0);
      add_word(ACT_TICK, 0, 0, 0, 1);
      add_word(ACT_TICK, 0, 0, 0, 1);
      add_word(ACT_TICK, 0, 0, 0, 1);
      repeat (4) add_word(ACT_POP_ENC, 0, 1, 0, 1);
      repeat (4) add_word(ACT_POP_BTN, 1, 0, 1, 0);
      add_word(ACT_IGNORED, 1, 1, 1, 1);
      drain();

      write_debounce(16'd1);
      queue_random(200, 6);
      drain();

      write_debounce(16'd0);
      queue_random(100, 6);
      drain();

      // longest period: waits start and bounces restart them, but none runs out
      write_debounce(16'hFFFF);
      queue_random(40, 20);
      drain();

      write_debounce(16'd7);
      queue_random(150, 25);
      drain();
      queue_random(150, 25);
      drain();

      write_debounce(DEBOUNCE_RESET);
      queue_random(260, 160);
      drain();
      repeat (8) @(posedge clock);

      $display("run: %0d request words, %0d results; debounce periods 0, 1, 2, 7, 50, 65535",
               words_sent, results_seen);
      $display("entries popped: %0d encoder, %0d button; peak fill %0d encoder, %0d button",
               enc_popped, btn_popped, enc_peak, btn_peak);
      if (error_count == 0) begin
         $display("[encoder_button_event_queue] OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[encoder_button_event_queue] ERROR");
      end
      $finish;
   end

endmodule
